// ----- hdl/irqt_pkg.sv -----
package irqt_pkg;

  localparam int PIX_W = 24;
  localparam int CNT_W = 13;
  localparam int DIM_W = 7;
  localparam int TOT_W = 2 * DIM_W;
  localparam int ANG_W = 10;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ANGLE    = 2'd1;
  localparam logic [1:0] ST_SHAPE    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic [1:0] REG_ANGLE = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;
  localparam logic [1:0] REG_WHOLE = 2'd3;

  typedef struct packed {
    logic             ok;
    logic [1:0]       turns;
  } angle_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
    logic [DIM_W-1:0] rem;
  } div_res_t;

  function automatic angle_t decode_angle(input logic signed [ANG_W-1:0] a);
    angle_t r;
    r.ok    = 1'b1;
    r.turns = 2'd0;
    priority if (a == 10'sd0 || a == 10'sd360 || a == -10'sd360) begin
      r.turns = 2'd0;
    end else if (a == 10'sd90 || a == -10'sd270) begin
      r.turns = 2'd1;
    end else if (a == 10'sd180 || a == -10'sd180) begin
      r.turns = 2'd2;
    end else if (a == 10'sd270 || a == -10'sd90) begin
      r.turns = 2'd3;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hdl/irqt_in_if.sv -----
interface irqt_in_if;
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [irqt_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink (input valid, input cmd, input pixel_in, output ready);
endinterface

// ----- hdl/irqt_out_if.sv -----
interface irqt_out_if;
  logic                       valid;
  logic                       ready;
  logic [irqt_pkg::PIX_W-1:0] pixel_out;
  logic                       last;
  logic [1:0]                 status;

  modport source (output valid, output pixel_out, output last, output status, input ready);
  modport sink (input valid, input pixel_out, input last, input status, output ready);
endinterface

// ----- hdl/image_rotate_by_quarter_turns.sv -----
// latency: a result is presented the cycle after its input transfer
// throughput: one load or fetch per cycle while the output is free and no resync runs, limited by the single store port
// a register write stalls the input while a serial divider
// rebuilds the output row and column from the fetch counter
// reset clears counters and sets the registers to their defaults; the pixel store is not cleared and
// pixels not yet loaded read as zero
module image_rotate_by_quarter_turns #(
  parameter int MAX_DIM    = 64,
  parameter int PIXEL_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  irqt_in_if.sink     in_i,
  irqt_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int DIM_CAP     = (MAX_DIM < 127) ? MAX_DIM : 127;
  localparam int CW          = irqt_pkg::CNT_W;
  localparam int DW          = irqt_pkg::DIM_W;
  localparam int TW          = irqt_pkg::TOT_W;

  // configuration registers
  logic [irqt_pkg::ANG_W-1:0] angle_q;
  logic [DW-1:0]              rows_q;
  logic [DW-1:0]              cols_q;
  logic                       whole_q;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      rows_q  <= DW'(1);
      cols_q  <= DW'(1);
      whole_q <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        irqt_pkg::REG_ANGLE: angle_q <= pwdata[irqt_pkg::ANG_W-1:0];
        irqt_pkg::REG_ROWS:  rows_q  <= pwdata[DW-1:0];
        irqt_pkg::REG_COLS:  cols_q  <= pwdata[DW-1:0];
        irqt_pkg::REG_WHOLE: whole_q <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      irqt_pkg::REG_ANGLE: prdata = 32'(angle_q);
      irqt_pkg::REG_ROWS:  prdata = 32'(rows_q);
      irqt_pkg::REG_COLS:  prdata = 32'(cols_q);
      irqt_pkg::REG_WHOLE: prdata = 32'(whole_q);
    endcase
  end

  // derived geometry
  logic [DW-1:0]   cap;
  logic [DW-1:0]   rows;
  logic [DW-1:0]   cols;
  logic [DW-1:0]   ocols;
  logic [TW-1:0]   total;
  irqt_pkg::angle_t ang;

  assign cap   = DW'(DIM_CAP);
  assign rows  = (rows_q == '0) ? DW'(1) : ((rows_q > cap) ? cap : rows_q);
  assign cols  = (cols_q == '0) ? DW'(1) : ((cols_q > cap) ? cap : cols_q);
  assign total = TW'(rows) * TW'(cols);
  assign ang   = irqt_pkg::decode_angle(angle_q);
  assign ocols = ang.turns[0] ? rows : cols;

  // counters
  logic [CW-1:0] load_cnt_q;
  logic [CW-1:0] fetch_cnt_q;
  logic [DW-1:0] oi_q;
  logic [DW-1:0] oj_q;
  logic [CW-1:0] k;

  assign k = ({1'b0, fetch_cnt_q} < total) ? fetch_cnt_q : '0;

  // output position resync after a register write
  logic               start_q;
  logic               sync_busy_q;
  irqt_pkg::div_res_t div_res;

  irqt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (k),
    .divisor_i  (ocols),
    .res_o      (div_res)
  );

  // item decode
  logic          out_free;
  logic          in_fire;
  logic          is_fetch;
  logic          load_ok;
  logic          fetch_ok;
  logic [1:0]    fetch_status;
  logic [TW-1:0] kp1;
  logic          is_last;
  logic [DW-1:0] sr;
  logic [DW-1:0] sc;
  logic [TW-1:0] src;
  logic          src_hit;
  logic          mem_we;
  logic          mem_re;

  assign out_free   = !out_o.valid || out_o.ready;
  assign in_i.ready = !sync_busy_q && out_free;
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_fetch   = (in_i.cmd == irqt_pkg::CMD_FETCH);

  assign load_ok = ({1'b0, load_cnt_q} < total) && (32'(load_cnt_q) < STORE_DEPTH);

  always_comb begin
    priority if (!ang.ok) begin
      fetch_status = irqt_pkg::ST_ANGLE;
    end else if (rows != cols && !whole_q) begin
      fetch_status = irqt_pkg::ST_SHAPE;
    end else begin
      fetch_status = irqt_pkg::ST_OK;
    end
  end

  assign fetch_ok = (fetch_status == irqt_pkg::ST_OK);
  assign kp1      = TW'(k) + TW'(1);
  assign is_last  = kp1 >= total;

  always_comb begin
    unique case (ang.turns)
      2'd1: begin
        sr = rows - DW'(1) - oj_q;
        sc = oi_q;
      end
      2'd2: begin
        sr = rows - DW'(1) - oi_q;
        sc = cols - DW'(1) - oj_q;
      end
      2'd3: begin
        sr = oj_q;
        sc = cols - DW'(1) - oi_q;
      end
      default: begin
        sr = oi_q;
        sc = oj_q;
      end
    endcase
  end

  assign src     = TW'(sr) * TW'(cols) + TW'(sc);
  assign src_hit = (src < {1'b0, load_cnt_q}) && (32'(src) < STORE_DEPTH);
  assign mem_we  = in_fire && !is_fetch && load_ok;
  assign mem_re  = in_fire && is_fetch && fetch_ok;

  // pixel store
  logic [PIXEL_BITS-1:0] mem_q [STORE_DEPTH];
  logic [PIXEL_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[AW'(load_cnt_q)] <= PIXEL_BITS'(in_i.pixel_in);
    end
    if (mem_re) begin
      rdata_q <= mem_q[AW'(src)];
    end
  end

  // control state
  logic       pix_sel_q;
  logic       last_q;
  logic [1:0] status_q;
  logic       out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      fetch_cnt_q <= '0;
      oi_q        <= '0;
      oj_q        <= '0;
      start_q     <= 1'b0;
      sync_busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      pix_sel_q   <= 1'b0;
      last_q      <= 1'b0;
      status_q    <= irqt_pkg::ST_OK;
    end else begin
      start_q <= cfg_wr;
      if (cfg_wr) begin
        sync_busy_q <= 1'b1;
      end else if (div_res.done && !start_q) begin
        sync_busy_q <= 1'b0;
        oi_q        <= DW'(div_res.quot);
        oj_q        <= div_res.rem;
      end

      if (in_fire) begin
        out_valid_q <= 1'b1;
        pix_sel_q   <= 1'b0;
        last_q      <= 1'b0;
        status_q    <= irqt_pkg::ST_OK;
        if (!is_fetch) begin
          if (load_ok) begin
            load_cnt_q <= load_cnt_q + 1'b1;
          end else begin
            status_q <= irqt_pkg::ST_OVERFLOW;
          end
        end else if (!fetch_ok) begin
          status_q <= fetch_status;
        end else begin
          pix_sel_q <= src_hit;
          if (is_last) begin
            last_q      <= 1'b1;
            fetch_cnt_q <= '0;
            load_cnt_q  <= '0;
            oi_q        <= '0;
            oj_q        <= '0;
          end else begin
            fetch_cnt_q <= CW'(kp1);
            if (oj_q == ocols - DW'(1)) begin
              oj_q <= '0;
              oi_q <= oi_q + 1'b1;
            end else begin
              oj_q <= oj_q + 1'b1;
            end
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.pixel_out = pix_sel_q ? irqt_pkg::PIX_W'(rdata_q) : '0;
  assign out_o.last      = last_q;
  assign out_o.status    = status_q;

  a_last_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last |-> out_o.status == irqt_pkg::ST_OK)
    else $error("last flagged on a failed result");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_fetch && fetch_ok && is_last |=> load_cnt_q == '0 && fetch_cnt_q == '0)
    else $error("counters not cleared after final fetch");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sync_busy_q |-> oj_q < ocols)
    else $error("output column outside the output row");

endmodule

// ----- hdl/irqt_div.sv -----
module irqt_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [irqt_pkg::CNT_W-1:0]   dividend_i,
  input  logic [irqt_pkg::DIM_W-1:0]   divisor_i,
  output irqt_pkg::div_res_t           res_o
);

  localparam int CW = irqt_pkg::CNT_W;
  localparam int DW = irqt_pkg::DIM_W;
  localparam int SW = $clog2(CW);

  logic          busy_q;
  logic          done_q;
  logic [SW-1:0] step_q;
  logic [CW-1:0] dvd_q;
  logic [CW-1:0] quot_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dsr_q;

  logic [DW:0]   trial;
  logic          ge;
  logic [DW-1:0] rem_d;

  assign trial = {rem_q, dvd_q[CW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign rem_d = ge ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == SW'(CW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[CW-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[CW-2:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import irqt_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_PRINTS   = 40;
  localparam int SIDE_MAX     = 64;
  localparam int STEPS        = 39;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;
  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic [1:0]       status;
  } rotated_px_t;

  typedef struct packed {
    row_kind_e        kind;
    logic [1:0]       reg_idx;
    logic [31:0]      value;
    logic             cmd;
    logic [PIX_W-1:0] pixel;
    logic             typed;
    rotated_px_t      want;
  } step_t;

  localparam rotated_px_t NO_CHECK = '0;

  localparam step_t PLAN [STEPS] = '{
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h000000, 1'b1, '{24'h000000, 1'b1, ST_OK}},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'hFFFFFF, 1'b1, '{24'h000000, 1'b0, ST_OK}},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'h000000, 1'b1,
      '{24'h000000, 1'b0, ST_OVERFLOW}},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h123456, 1'b1, '{24'hFFFFFF, 1'b1, ST_OK}},
    '{ROW_CFG, REG_ANGLE, 32'd45, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'hFFFFFF, 1'b1, '{24'h000000, 1'b0, ST_ANGLE}},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'hA5A5A5, 1'b1, '{24'h000000, 1'b0, ST_OK}},
    '{ROW_CFG, REG_ANGLE, 32'd511, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b1, '{24'h000000, 1'b0, ST_ANGLE}},
    '{ROW_CFG, REG_ANGLE, -32'sd512, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b1, '{24'h000000, 1'b0, ST_ANGLE}},
    '{ROW_CFG, REG_ANGLE, -32'sd90, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_ROWS, 32'd2, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_COLS, 32'd3, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_WHOLE, 32'd0, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b1, '{24'h000000, 1'b0, ST_SHAPE}},
    '{ROW_CFG, REG_ANGLE, 32'd450, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b1, '{24'h000000, 1'b0, ST_ANGLE}},
    '{ROW_CFG, REG_WHOLE, 32'd1, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_ANGLE, -32'sd90, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'h111111, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'h222222, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'h333333, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'h444444, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'h555555, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_ROWS, 32'd0, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_COLS, 32'd127, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_ANGLE, 32'd360, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_LOAD, 24'h800000, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK},
    '{ROW_CFG, REG_COLS, 32'd1, CMD_LOAD, 24'h0, 1'b0, NO_CHECK},
    '{ROW_ITEM, REG_ANGLE, 32'd0, CMD_FETCH, 24'h0, 1'b0, NO_CHECK}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  irqt_in_if  in_bus ();
  irqt_out_if out_bus ();

  image_rotate_by_quarter_turns dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [PIX_W-1:0]        pixel_copy [SIDE_MAX*SIDE_MAX];
  logic [CNT_W-1:0]        loads_held   = '0;
  logic [CNT_W-1:0]        fetches_done = '0;
  logic signed [ANG_W-1:0] angle_reg    = '0;
  logic [DIM_W-1:0]        rows_reg     = 7'd1;
  logic [DIM_W-1:0]        cols_reg     = 7'd1;
  logic                    whole_reg    = 1'b1;

  rotated_px_t pending_outputs [$];
  int mismatch_count = 0;
  int items_accepted = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  function automatic int clamp_side(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > SIDE_MAX) return SIDE_MAX;
    return int'(d);
  endfunction

  function automatic rotated_px_t rotate_predict(logic cmd, logic [PIX_W-1:0] pix);
    int rows, cols, total, ang, turns, out_cols, k, oi, oj, sr, sc, src;
    rotated_px_t r;
    rows  = clamp_side(rows_reg);
    cols  = clamp_side(cols_reg);
    total = rows * cols;
    r     = '0;
    if (cmd == CMD_LOAD) begin
      if (int'(loads_held) < total) begin
        pixel_copy[loads_held] = pix;
        loads_held = loads_held + 1'b1;
      end else begin
        r.status = ST_OVERFLOW;
      end
    end else begin
      ang = angle_reg;
      if (ang > 360 || ang < -360 || ang % 90 != 0) begin
        r.status = ST_ANGLE;
      end else if (rows != cols && !whole_reg) begin
        r.status = ST_SHAPE;
      end else begin
        turns    = ((ang / 90) % 4 + 4) % 4;
        out_cols = (turns % 2 == 1) ? rows : cols;
        k        = (int'(fetches_done) < total) ? int'(fetches_done) : 0;
        oi       = k / out_cols;
        oj       = k % out_cols;
        case (turns)
          1: begin
            sr = rows - 1 - oj;
            sc = oi;
          end
          2: begin
            sr = rows - 1 - oi;
            sc = cols - 1 - oj;
          end
          3: begin
            sr = oj;
            sc = cols - 1 - oi;
          end
          default: begin
            sr = oi;
            sc = oj;
          end
        endcase
        src = sr * cols + sc;
        // pixels not loaded yet read as zero
        if (src < int'(loads_held)) r.pixel = pixel_copy[src];
        if (k + 1 >= total) begin
          r.last       = 1'b1;
          fetches_done = '0;
          loads_held   = '0;
        end else begin
          fetches_done = CNT_W'(k + 1);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    if ($urandom_range(99) < 10) return $urandom_range(1) ? '1 : '0;
    return PIX_W'($urandom());
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("%0t ns: %s", $realtime, what);
  endtask

  task automatic send_item(logic cmd, logic [PIX_W-1:0] pix, logic typed, rotated_px_t want);
    rotated_px_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.cmd      <= cmd;
    in_bus.pixel_in <= pix;
    do @(posedge clk_i); while (!in_bus.ready);
    predicted = rotate_predict(cmd, pix);
    pending_outputs.push_back(typed ? want : predicted);
    items_accepted++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ANGLE: angle_reg = value[ANG_W-1:0];
      REG_ROWS:  rows_reg  = value[DIM_W-1:0];
      REG_COLS:  cols_reg  = value[DIM_W-1:0];
      REG_WHOLE: whole_reg = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_region();
    int   big, little, rdim, cdim, ang, pick, total, n_load, n_fetch;
    logic whole;
    if ($urandom_range(99) < 85) begin
      rdim = $urandom_range(1, 6);
      cdim = $urandom_range(1, 6);
    end else begin
      case ($urandom_range(3))
        0: big = 0;
        1: big = SIDE_MAX;
        2: big = 127;
        default: big = $urandom_range(7, SIDE_MAX);
      endcase
      little = $urandom_range(0, 4);
      if ($urandom_range(1)) begin
        rdim = big;
        cdim = little;
      end else begin
        rdim = little;
        cdim = big;
      end
    end
    whole = 1'($urandom_range(1));
    if (!whole && rdim <= 6 && $urandom_range(99) < 70) cdim = rdim;
    if ($urandom_range(99) < 75) ang = 90 * int'($urandom_range(8)) - 360;
    else ang = int'($urandom_range(1023)) - 512;

    settle();
    cfg_write(REG_ANGLE, 32'(ang));
    cfg_write(REG_ROWS, 32'(rdim));
    cfg_write(REG_COLS, 32'(cdim));
    cfg_write(REG_WHOLE, {31'd0, whole});

    total = clamp_side(rows_reg) * clamp_side(cols_reg);
    pick  = $urandom_range(99);
    if (pick < 70) begin
      // fill the region, maybe overfill, then read the rest of the turned region
      n_load = total - int'(loads_held);
      if (n_load < 0) n_load = 0;
      if ($urandom_range(99) < 20) n_load += $urandom_range(1, 3);
      n_fetch = total - ((int'(fetches_done) < total) ? int'(fetches_done) : 0);
      repeat (n_load) send_item(CMD_LOAD, random_pixel(), 1'b0, NO_CHECK);
      repeat (n_fetch) send_item(CMD_FETCH, random_pixel(), 1'b0, NO_CHECK);
    end else if (pick < 85) begin
      n_load  = $urandom_range(0, total);
      n_fetch = $urandom_range(0, total);
      repeat (n_load) send_item(CMD_LOAD, random_pixel(), 1'b0, NO_CHECK);
      repeat (n_fetch) send_item(CMD_FETCH, random_pixel(), 1'b0, NO_CHECK);
    end else begin
      repeat ($urandom_range(5, 20)) begin
        send_item(1'($urandom_range(1)), random_pixel(), 1'b0, NO_CHECK);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    rotated_px_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (pending_outputs.size() == 0) begin
        flag_mismatch($sformatf("transfer out with nothing pending: pixel_out %h status %0d",
                                out_bus.pixel_out, out_bus.status));
      end else begin
        want = pending_outputs.pop_front();
        if (out_bus.pixel_out !== want.pixel) begin
          flag_mismatch($sformatf("pixel_out %h, expected %h", out_bus.pixel_out, want.pixel));
        end
        if (out_bus.last !== want.last) begin
          flag_mismatch($sformatf("last %b, expected %b", out_bus.last, want.last));
        end
        if (out_bus.status !== want.status) begin
          flag_mismatch($sformatf("status %0d, expected %0d", out_bus.status, want.status));
        end
      end
    end
  end

  initial begin
    int    phase_goal;
    pace_e pace;
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.cmd      = CMD_LOAD;
    in_bus.pixel_in = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < STEPS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        settle();
        cfg_write(PLAN[i].reg_idx, PLAN[i].value);
      end else begin
        send_item(PLAN[i].cmd, PLAN[i].pixel, PLAN[i].typed, PLAN[i].want);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      pace = pace_e'(ph);
      case (pace)
        PACE_FULL: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        PACE_SEND_GAPS: begin
          send_idle_pct  = 78;
          recv_stall_pct = 0;
        end
        PACE_RECV_STALLS: begin
          send_idle_pct  = 0;
          recv_stall_pct = 78;
        end
        default: begin
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      phase_goal = items_accepted + RANDOM_ITEMS / 4;
      while (items_accepted < phase_goal) random_region();
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
